// ===== hdl/afsf_pkg.sv =====
// Shared constants and types for the fade-out / switch / fade-in block.
`timescale 1ns / 1ps
`default_nettype none
package afsf_pkg;

  localparam int FADE_FRAMES   = 5;
  localparam int MAX_FRAME_LEN = 4096;

  localparam int SAMPLE_W  = 24;
  localparam int FLEN_W    = 13;
  localparam int CHCNT_W   = 5;
  localparam int CHPOS_W   = 4;
  localparam int LEN_W     = $clog2(MAX_FRAME_LEN + 1);
  localparam int POS_W     = $clog2(MAX_FRAME_LEN);
  localparam int DEN_W     = $clog2(FADE_FRAMES * MAX_FRAME_LEN + 1);
  localparam int FC_W      = $clog2(FADE_FRAMES + 1) + 1;
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = GAIN_FRAC + 1;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
  localparam int STEP_W    = $clog2(GAIN_FRAC);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int REQ_W       = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_FADE   = 2'd1,
    REQ_SET    = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  localparam logic REG_FRAME_LEN = 1'b0;
  localparam logic REG_CHAN_CNT  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic active;
    logic pulse;
    logic enable;
  } item_flags_t;

endpackage
`default_nettype wire

// ===== hdl/audio_fade_out_switch_fade_in.sv =====
// Top level: frame tracking, fade state, sequencer and output register.
//
// Input stream: in_tuser carries the request kind (sample, fade request,
// direct enable set); in_tdata carries the Q1.23 sample and the target
// enable. Only samples give a result on the output stream, one each.
// Output tdata: faded sample, fade active, switch pulse, applied enable.
// A sample outside a fade goes to S_OUT, which loads the output register
// once it is free; the next request is taken after that. A sample inside
// a fade goes through S_DIV, S_MUL and S_OUT: the shared divider forms the
// top gain bit at acceptance and the other 16 one a cycle, its done flag
// hands over to S_MUL, which registers the product, and S_OUT rounds,
// saturates and loads the output register. Other requests give no result
// and leave the block idle for the next one. in_tready stays low while a
// sample is at work and while a finished result waits for the output
// register to free; the output register holds through a stall. frame_len
// and channel_count are written through cfg_* while idle, which the user
// must keep to: the block does not enforce it. Any write moves the
// position back to a frame start. Reset (rst_n low, synchronous) restores
// frame_len 960, channel_count 2 and clears all fade and enable state.
`timescale 1ns / 1ps
`default_nettype none
module audio_fade_out_switch_fade_in (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [23:0] sample_in, [24] enable_target, [31:25] zero
  input  wire logic [afsf_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [1:0] req_type
  input  wire logic [afsf_pkg::REQ_W-1:0]           in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [23:0] sample_out, [24] fade_active, [25] switch_pulse, [26] enable_now, [31:27] zero
  output logic [afsf_pkg::OUT_TDATA_W-1:0]          out_tdata,
  input  wire logic                                 cfg_we,
  input  wire logic                                 cfg_index,
  input  wire logic [afsf_pkg::FLEN_W-1:0]          cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_OUT
  } state_t;

  localparam int F = afsf_pkg::FADE_FRAMES;
  localparam logic signed [afsf_pkg::FC_W-1:0] FC_F = afsf_pkg::FC_W'(F);

  state_t                                   state_r, state_nxt;
  logic [afsf_pkg::FLEN_W-1:0]              frame_len_r, frame_len_nxt;
  logic [afsf_pkg::CHCNT_W-1:0]             chan_cnt_r, chan_cnt_nxt;
  logic signed [afsf_pkg::FC_W-1:0]         fade_r, fade_nxt;
  logic                                     applied_r, applied_nxt;
  logic                                     pending_r, pending_nxt;
  logic                                     load_r, load_nxt;
  logic [afsf_pkg::POS_W-1:0]               spos_r, spos_nxt;
  logic [afsf_pkg::CHPOS_W-1:0]             cpos_r, cpos_nxt;
  afsf_pkg::item_flags_t                    flags_r, flags_nxt;
  logic signed [afsf_pkg::SAMPLE_W-1:0]     sample_r, sample_nxt;
  logic                                     out_valid_r, out_valid_nxt;
  logic [afsf_pkg::OUT_TDATA_W-1:0]         out_data_r, out_data_nxt;

  logic                                     accept;
  afsf_pkg::req_type_t                      req;
  logic                                     target;
  logic signed [afsf_pkg::SAMPLE_W-1:0]     sample_in;
  logic [afsf_pkg::LEN_W-1:0]               len_c;
  logic [afsf_pkg::CHPOS_W-1:0]             chans_m1;
  logic [afsf_pkg::POS_W-1:0]               sp_c;
  logic [afsf_pkg::CHPOS_W-1:0]             cp_c;
  logic                                     load_now;
  logic signed [afsf_pkg::FC_W-1:0]         fc_c;
  logic [afsf_pkg::FC_W-1:0]                mult_c;
  logic [afsf_pkg::DEN_W-1:0]               base_c;
  logic [afsf_pkg::DEN_W-1:0]               num_c;
  logic [afsf_pkg::DEN_W-1:0]               den_c;
  logic                                     chan_last;
  logic                                     samp_last;
  logic                                     div_start;
  afsf_pkg::div_stat_t                      div_stat;
  logic [afsf_pkg::GAIN_W-1:0]              gain;
  logic signed [afsf_pkg::SAMPLE_W-1:0]     scaled;
  logic signed [afsf_pkg::SAMPLE_W-1:0]     res_c;
  logic                                     out_free;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign req       = afsf_pkg::req_type_t'(in_tuser);
  assign target    = in_tdata[afsf_pkg::SAMPLE_W];
  assign sample_in = in_tdata[afsf_pkg::SAMPLE_W-1:0];
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    priority if (frame_len_r == '0) begin
      len_c = afsf_pkg::LEN_W'(1);
    end else if (32'(frame_len_r) > afsf_pkg::MAX_FRAME_LEN) begin
      len_c = afsf_pkg::LEN_W'(afsf_pkg::MAX_FRAME_LEN);
    end else begin
      len_c = afsf_pkg::LEN_W'(frame_len_r);
    end
    priority if (chan_cnt_r == '0) begin
      chans_m1 = '0;
    end else if (chan_cnt_r > afsf_pkg::CHCNT_W'(16)) begin
      chans_m1 = '1;
    end else begin
      chans_m1 = afsf_pkg::CHPOS_W'(chan_cnt_r - 1'b1);
    end
  end

  always_comb begin
    sp_c = spos_r;
    if (afsf_pkg::LEN_W'(spos_r) >= len_c) begin
      sp_c = afsf_pkg::POS_W'(len_c - 1'b1);
    end
    cp_c = (cpos_r > chans_m1) ? chans_m1 : cpos_r;
    load_now  = (sp_c == '0) && (cp_c == '0) && load_r;
    fc_c      = load_now ? FC_F : fade_r;
    mult_c    = (fc_c > 0) ? afsf_pkg::FC_W'(fc_c) : afsf_pkg::FC_W'(FC_F + fc_c);
    base_c    = afsf_pkg::DEN_W'(mult_c) * afsf_pkg::DEN_W'(len_c);
    num_c     = (fc_c > 0) ? (base_c - afsf_pkg::DEN_W'(sp_c))
                           : (base_c + afsf_pkg::DEN_W'(sp_c));
    den_c     = afsf_pkg::DEN_W'(F) * afsf_pkg::DEN_W'(len_c);
    chan_last = (cp_c == chans_m1);
    samp_last = (afsf_pkg::LEN_W'(sp_c) == len_c - afsf_pkg::LEN_W'(1));
  end

  assign div_start = accept && (req == afsf_pkg::REQ_SAMPLE) && (fc_c != '0);
  assign res_c     = flags_r.active ? scaled : sample_r;

  always_comb begin
    state_nxt     = state_r;
    frame_len_nxt = frame_len_r;
    chan_cnt_nxt  = chan_cnt_r;
    fade_nxt      = fade_r;
    applied_nxt   = applied_r;
    pending_nxt   = pending_r;
    load_nxt      = load_r;
    spos_nxt      = spos_r;
    cpos_nxt      = cpos_r;
    flags_nxt     = flags_r;
    sample_nxt    = sample_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        afsf_pkg::REG_FRAME_LEN: frame_len_nxt = cfg_wdata;
        afsf_pkg::REG_CHAN_CNT:  chan_cnt_nxt  = afsf_pkg::CHCNT_W'(cfg_wdata);
        default:                 frame_len_nxt = frame_len_r;
      endcase
      spos_nxt = '0;
      cpos_nxt = '0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (req)
            afsf_pkg::REQ_FADE: begin
              if (target != pending_r) begin
                pending_nxt = target;
                load_nxt    = 1'b1;
              end
            end
            afsf_pkg::REQ_SET: begin
              applied_nxt = target;
              pending_nxt = target;
            end
            afsf_pkg::REQ_SAMPLE: begin
              sample_nxt       = sample_in;
              flags_nxt.active = (fc_c != '0);
              flags_nxt.pulse  = 1'b0;
              flags_nxt.enable = applied_r;
              if (load_now) begin
                load_nxt = 1'b0;
              end
              fade_nxt = fc_c;
              cpos_nxt = chan_last ? '0 : cp_c + 1'b1;
              spos_nxt = chan_last ? (samp_last ? '0 : sp_c + 1'b1) : sp_c;
              if (chan_last && samp_last) begin
                if (fc_c > 0) begin
                  if (fc_c == afsf_pkg::FC_W'(1)) begin
                    fade_nxt         = -FC_F;
                    applied_nxt      = pending_r;
                    flags_nxt.pulse  = 1'b1;
                    flags_nxt.enable = pending_r;
                  end else begin
                    fade_nxt = fc_c - 1'b1;
                  end
                end else if (fc_c < 0) begin
                  fade_nxt = fc_c + 1'b1;
                end
              end
              state_nxt = (fc_c != '0) ? S_DIV : S_OUT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(afsf_pkg::OUT_TDATA_W - afsf_pkg::SAMPLE_W - 3){1'b0}},
                           flags_r.enable, flags_r.pulse, flags_r.active, res_c};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_len_r <= afsf_pkg::FLEN_W'(960);
      chan_cnt_r  <= afsf_pkg::CHCNT_W'(2);
      fade_r      <= '0;
      applied_r   <= 1'b0;
      pending_r   <= 1'b0;
      load_r      <= 1'b0;
      spos_r      <= '0;
      cpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_len_r <= frame_len_nxt;
      chan_cnt_r  <= chan_cnt_nxt;
      fade_r      <= fade_nxt;
      applied_r   <= applied_nxt;
      pending_r   <= pending_nxt;
      load_r      <= load_nxt;
      spos_r      <= spos_nxt;
      cpos_r      <= cpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    flags_r    <= flags_nxt;
    sample_r   <= sample_nxt;
    out_data_r <= out_data_nxt;
  end

  afsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_c),
    .den   (den_c),
    .stat  (div_stat),
    .quot  (gain)
  );

  afsf_scale u_scale (
    .clk    (clk),
    .load   (state_r == S_MUL),
    .sample (sample_r),
    .gain   (gain),
    .result (scaled)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("input ready while the divider is busy");

  a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fade_r <= FC_F) && (fade_r >= -FC_F))
    else $error("fade count out of range");

  a_pulse_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[afsf_pkg::SAMPLE_W+1] |-> out_data_r[afsf_pkg::SAMPLE_W])
    else $error("switch pulse outside a fade");

endmodule
`default_nettype wire

// ===== hdl/afsf_div.sv =====
// Iterative restoring divider: gain = (num * 2^16 + den / 2) / den, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module afsf_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [afsf_pkg::DEN_W-1:0]        num,
  input  wire logic [afsf_pkg::DEN_W-1:0]        den,
  output afsf_pkg::div_stat_t                    stat,
  output logic      [afsf_pkg::GAIN_W-1:0]       quot
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [afsf_pkg::STEP_W-1:0]         cnt_r, cnt_nxt;
  logic [afsf_pkg::DEN_W-1:0]          rem_r, rem_nxt;
  logic [afsf_pkg::DEN_W-1:0]          den_r, den_nxt;
  logic [afsf_pkg::GAIN_FRAC-1:0]      half_r, half_nxt;
  logic [afsf_pkg::GAIN_W-1:0]         q_r, q_nxt;
  logic [afsf_pkg::DEN_W:0]            trial;
  logic [afsf_pkg::DEN_W:0]            diff;
  logic                                ge;
  logic                                top_ge;

  assign trial  = {rem_r, half_r[afsf_pkg::GAIN_FRAC-1]};
  assign ge     = trial >= {1'b0, den_r};
  assign diff   = trial - {1'b0, den_r};
  assign top_ge = num >= den;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    half_nxt = half_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = den;
      half_nxt = afsf_pkg::GAIN_FRAC'(den >> 1);
      rem_nxt  = top_ge ? (num - den) : num;
      q_nxt    = {{afsf_pkg::GAIN_FRAC{1'b0}}, top_ge};
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[afsf_pkg::DEN_W-1:0] : trial[afsf_pkg::DEN_W-1:0];
      q_nxt    = {q_r[afsf_pkg::GAIN_W-2:0], ge};
      half_nxt = {half_r[afsf_pkg::GAIN_FRAC-2:0], 1'b0};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == {afsf_pkg::STEP_W{1'b1}}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    half_r <= half_nxt;
    q_r    <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule
`default_nettype wire

// ===== hdl/afsf_scale.sv =====
// Gain multiply with registered product, then round half up and saturate to 24 bits.
`timescale 1ns / 1ps
`default_nettype none
module afsf_scale (
  input  wire logic                                clk,
  input  wire logic                                load,
  input  wire logic signed [afsf_pkg::SAMPLE_W-1:0] sample,
  input  wire logic        [afsf_pkg::GAIN_W-1:0]   gain,
  output logic      signed [afsf_pkg::SAMPLE_W-1:0] result
);

  localparam int SH_W = afsf_pkg::PROD_W - afsf_pkg::GAIN_FRAC;
  localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'((1 << (afsf_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_MIN = -SH_W'(1 << (afsf_pkg::SAMPLE_W - 1));

  logic        [afsf_pkg::GAIN_W-1:0] gain_c;
  logic signed [afsf_pkg::GAIN_W:0]   gain_s;
  logic signed [afsf_pkg::PROD_W-1:0] prod_r;
  logic signed [afsf_pkg::PROD_W-1:0] rnd;
  logic signed [SH_W-1:0]             shr;

  always_comb begin
    gain_c = gain;
    if (gain[afsf_pkg::GAIN_W-1]) begin
      gain_c = afsf_pkg::GAIN_W'(1 << afsf_pkg::GAIN_FRAC);
    end
  end

  assign gain_s = $signed({1'b0, gain_c});

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= afsf_pkg::PROD_W'(sample * gain_s);
    end
  end

  assign rnd = prod_r + afsf_pkg::PROD_W'(1 << (afsf_pkg::GAIN_FRAC - 1));
  assign shr = rnd[afsf_pkg::PROD_W-1:afsf_pkg::GAIN_FRAC];

  always_comb begin
    priority if (shr > SAT_MAX) begin
      result = SAT_MAX[afsf_pkg::SAMPLE_W-1:0];
    end else if (shr < SAT_MIN) begin
      result = SAT_MIN[afsf_pkg::SAMPLE_W-1:0];
    end else begin
      result = shr[afsf_pkg::SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the fade block: stream stimulus, fade predictor, result checks.
`timescale 1ns / 1ps
module testbench;

  localparam int NUM_SEGS    = 9;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;
  localparam int STALL_LIMIT = 4000;
  localparam int SEG_FLEN  [NUM_SEGS] = '{4, 1, 0, 8191, 7, 2, 0, 3, 5};
  localparam int SEG_CHAN  [NUM_SEGS] = '{2, 1, 0, 31, 3, 16, 0, 1, 2};
  localparam int SEG_ITEMS [NUM_SEGS] = '{150, 100, 80, 60, 150, 100, 150, 150, 110};

  typedef struct packed {
    logic [afsf_pkg::SAMPLE_W-1:0] smp;
    logic                          active;
    logic                          pulse;
    logic                          enable;
  } fade_result_t;

  class fade_scoreboard;
    logic [afsf_pkg::FLEN_W-1:0]  frame_len;
    logic [afsf_pkg::CHCNT_W-1:0] chan_cnt;
    int                           fade_cnt;
    bit                           applied_en;
    bit                           pending_en;
    bit                           load_pending;
    longint                       smp_pos;
    longint                       ch_pos;
    fade_result_t                 expected_q[$];
    int                           errors;

    function new();
      frame_len    = 13'd960;
      chan_cnt     = 5'd2;
      fade_cnt     = 0;
      applied_en   = 1'b0;
      pending_en   = 1'b0;
      load_pending = 1'b0;
      smp_pos      = 0;
      ch_pos       = 0;
      errors       = 0;
    endfunction

    function void write_reg(logic idx, logic [afsf_pkg::FLEN_W-1:0] value);
      if (idx == afsf_pkg::REG_FRAME_LEN) frame_len = value;
      else chan_cnt = value[afsf_pkg::CHCNT_W-1:0];
      smp_pos = 0;
      ch_pos  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(afsf_pkg::req_type_t kind,
                               logic [afsf_pkg::IN_TDATA_W-1:0] data);
      bit           tgt;
      longint       len, chans, s, num, den, g, r;
      bit           frame_end;
      fade_result_t res;
      tgt = data[afsf_pkg::SAMPLE_W];
      case (kind)
        afsf_pkg::REQ_FADE: begin
          if (tgt != pending_en) begin
            pending_en   = tgt;
            load_pending = 1'b1;
          end
        end
        afsf_pkg::REQ_SET: begin
          applied_en = tgt;
          pending_en = tgt;
        end
        afsf_pkg::REQ_SAMPLE: begin
          len   = (frame_len == 0) ? 1 :
                  (frame_len > afsf_pkg::MAX_FRAME_LEN ? afsf_pkg::MAX_FRAME_LEN : frame_len);
          chans = (chan_cnt == 0) ? 1 : (chan_cnt > 16 ? 16 : chan_cnt);
          if (smp_pos >= len) smp_pos = len - 1;
          if (ch_pos >= chans) ch_pos = chans - 1;
          if (smp_pos == 0 && ch_pos == 0 && load_pending) begin
            fade_cnt     = afsf_pkg::FADE_FRAMES;
            load_pending = 1'b0;
          end
          s = $signed(data[afsf_pkg::SAMPLE_W-1:0]);
          r = s;
          res.active = (fade_cnt != 0);
          if (fade_cnt != 0) begin
            den = afsf_pkg::FADE_FRAMES * len;
            if (fade_cnt > 0) num = fade_cnt * len - smp_pos;
            else num = (afsf_pkg::FADE_FRAMES + fade_cnt) * len + smp_pos;
            g = (num * 65536 + den / 2) / den;
            if (g > 65536) g = 65536;
            r = (s * g + 32768) >>> 16;
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
          end
          frame_end = (ch_pos + 1 >= chans) && (smp_pos + 1 >= len);
          if (ch_pos + 1 >= chans) begin
            ch_pos  = 0;
            smp_pos = (smp_pos + 1 >= len) ? 0 : smp_pos + 1;
          end else begin
            ch_pos++;
          end
          res.pulse = 1'b0;
          if (frame_end) begin
            if (fade_cnt > 0) begin
              fade_cnt--;
              if (fade_cnt == 0) begin
                fade_cnt   = -afsf_pkg::FADE_FRAMES;
                applied_en = pending_en;
                res.pulse  = 1'b1;
              end
            end else if (fade_cnt < 0) begin
              fade_cnt++;
            end
          end
          res.smp    = r[afsf_pkg::SAMPLE_W-1:0];
          res.enable = applied_en;
          expected_q.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [afsf_pkg::OUT_TDATA_W-1:0] got);
      fade_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got[23:0] !== want.smp) begin
        $display("%0t: sample_out expected %h, got %h", $time, want.smp, got[23:0]);
        errors++;
      end
      if (got[24] !== want.active) begin
        $display("%0t: fade_active expected %b, got %b", $time, want.active, got[24]);
        errors++;
      end
      if (got[25] !== want.pulse) begin
        $display("%0t: switch_pulse expected %b, got %b", $time, want.pulse, got[25]);
        errors++;
      end
      if (got[26] !== want.enable) begin
        $display("%0t: enable_now expected %b, got %b", $time, want.enable, got[26]);
        errors++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [afsf_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [afsf_pkg::REQ_W-1:0]       in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [afsf_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_we;
  logic                             cfg_index;
  logic [afsf_pkg::FLEN_W-1:0]      cfg_wdata;

  fade_scoreboard sb = new();
  int             tx_idle_pct;
  int             rx_idle_pct;
  bit             hold_req;
  int             hold_left;
  int             stall_cycles;

  audio_fade_out_switch_fade_in u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_request(afsf_pkg::req_type_t'(in_tuser), in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // hold off the output for a long stretch on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(afsf_pkg::req_type_t kind,
                           logic [afsf_pkg::SAMPLE_W-1:0] smp, bit tgt);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, tgt, smp};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic configure(logic [afsf_pkg::FLEN_W-1:0] flen,
                           logic [afsf_pkg::FLEN_W-1:0] chw);
    cfg_we    <= 1'b1;
    cfg_index <= afsf_pkg::REG_FRAME_LEN;
    cfg_wdata <= flen;
    @(posedge clk);
    sb.write_reg(afsf_pkg::REG_FRAME_LEN, flen);
    cfg_index <= afsf_pkg::REG_CHAN_CNT;
    cfg_wdata <= chw;
    @(posedge clk);
    sb.write_reg(afsf_pkg::REG_CHAN_CNT, chw);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(int count);
    int                            pick;
    bit                            tgt;
    logic [afsf_pkg::SAMPLE_W-1:0] smp;
    repeat (count) begin
      pick = $urandom_range(999);
      smp  = afsf_pkg::SAMPLE_W'($urandom);
      tgt  = 1'($urandom_range(1));
      case ($urandom_range(15))
        0: smp = 24'h7FFFFF;
        1: smp = 24'h800000;
        default: ;
      endcase
      if (pick < 20) send_item(afsf_pkg::REQ_FADE, smp, tgt);
      else if (pick < 26) send_item(afsf_pkg::REQ_SET, smp, tgt);
      else if (pick < 40) send_item(afsf_pkg::REQ_NONE, smp, tgt);
      else send_item(afsf_pkg::REQ_SAMPLE, smp, tgt);
    end
  endtask

  initial begin
    int flen, chw;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = afsf_pkg::REQ_SAMPLE;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = afsf_pkg::REG_FRAME_LEN;
    cfg_wdata    = '0;
    hold_req     = 1'b0;
    hold_left    = 0;
    stall_cycles = 0;
    tx_idle_pct  = 13;
    rx_idle_pct  = 73;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through at reset configuration
    send_item(afsf_pkg::REQ_SAMPLE, 24'h7FFFFF, 1'b0);
    send_item(afsf_pkg::REQ_SAMPLE, 24'h800000, 1'b1);
    send_item(afsf_pkg::REQ_NONE, 24'h5A5A5A, 1'b1);
    send_item(afsf_pkg::REQ_SAMPLE, 24'h000000, 1'b0);
    send_item(afsf_pkg::REQ_SAMPLE, 24'hFFFFFF, 1'b0);
    drain();

    configure(13'd3, 13'd1);
    send_item(afsf_pkg::REQ_FADE, 24'hA5A5A5, 1'b0);
    send_item(afsf_pkg::REQ_FADE, 24'h000000, 1'b1);
    send_item(afsf_pkg::REQ_SAMPLE, 24'h7FFFFF, 1'b0);
    send_item(afsf_pkg::REQ_SAMPLE, 24'h800000, 1'b0);
    send_item(afsf_pkg::REQ_FADE, 24'hFFFFFF, 1'b1);
    send_item(afsf_pkg::REQ_SAMPLE, 24'h400000, 1'b1);
    send_item(afsf_pkg::REQ_SAMPLE, 24'hC00000, 1'b0);
    send_item(afsf_pkg::REQ_SET, 24'h123456, 1'b0);
    send_item(afsf_pkg::REQ_SAMPLE, 24'hFFFFFF, 1'b0);
    send_item(afsf_pkg::REQ_FADE, 24'h654321, 1'b1);
    send_item(afsf_pkg::REQ_SAMPLE, 24'h000001, 1'b0);
    send_item(afsf_pkg::REQ_SAMPLE, 24'h7FFFFF, 1'b1);
    send_item(afsf_pkg::REQ_SAMPLE, 24'h800000, 1'b0);
    repeat (6) send_item(afsf_pkg::REQ_SAMPLE, 24'h7FFFFF, 1'b0);
    send_item(afsf_pkg::REQ_SET, 24'h000000, 1'b1);
    send_item(afsf_pkg::REQ_SAMPLE, 24'h800001, 1'b0);
    drain();

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      if (seg < 3) begin
        tx_idle_pct = 13;
        rx_idle_pct = 73;
      end else if (seg < 6) begin
        tx_idle_pct = 73;
        rx_idle_pct = 13;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      flen = SEG_FLEN[seg];
      chw  = SEG_CHAN[seg] | ($urandom_range(255) << afsf_pkg::CHCNT_W);
      if (seg == 6) begin
        flen = $urandom_range(1, 12);
        chw  = $urandom_range(1, 5);
      end
      configure(afsf_pkg::FLEN_W'(flen), afsf_pkg::FLEN_W'(chw));
      if (seg == 0 || seg == 4) hold_req = 1'b1;
      send_random(SEG_ITEMS[seg]);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/afsf_pkg.sv
hdl/afsf_div.sv
hdl/afsf_scale.sv
hdl/audio_fade_out_switch_fade_in.sv
tb/testbench.sv
